// ===== rtl/core/sfc_pkg.sv =====
package sfc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int FRAC_W   = 15;

  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [5:0]                 tap_index;
    logic signed [SAMPLE_W-1:0] tap_value;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } res_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic rotate;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sfc_cell.sv =====
module sfc_cell
  import sfc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cell_ctrl_t                 ctrl,
  input  logic                       load,
  input  logic signed [SAMPLE_W-1:0] load_value,
  input  logic signed [SAMPLE_W-1:0] prev_sample,
  input  logic signed [SAMPLE_W-1:0] next_coef,
  input  logic signed [SAMPLE_W-1:0] next_sample,
  output logic signed [SAMPLE_W-1:0] coef,
  output logic signed [SAMPLE_W-1:0] sample
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef   <= '0;
      sample <= '0;
    end else begin
      if (load) begin
        coef <= load_value;
      end
      // rotate moves the whole pair one cell toward the head
      if (ctrl.rotate) begin
        coef   <= next_coef;
        sample <= next_sample;
      end else if (ctrl.shift) begin
        sample <= prev_sample;
      end else if (ctrl.clear) begin
        sample <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/sfc_mac.sv =====
module sfc_mac
  import sfc_pkg::*;
#(
  parameter int ACC_W = 39
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr,
  input  logic                       mul_en,
  input  logic signed [SAMPLE_W-1:0] coef,
  input  logic signed [SAMPLE_W-1:0] sample,
  output res_t                       result
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    prod <= coef * sample;
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, floor shift, clamp to Q1.15
  always_comb begin
    rounded = acc + ACC_W'(1 << (FRAC_W - 1));
    shifted = rounded >>> FRAC_W;
    if (shifted > $signed(ACC_W'(32767))) begin
      result.sample_out = 16'sh7FFF;
      result.saturated  = 1'b1;
    end else if (shifted < -$signed(ACC_W'(32768))) begin
      result.sample_out = -16'sh8000;
      result.saturated  = 1'b1;
    end else begin
      result.sample_out = shifted[SAMPLE_W-1:0];
      result.saturated  = 1'b0;
    end
  end

endmodule

// ===== rtl/core/streaming_fir_convolver.sv =====
// Filter request: the new sample is shifted in as the request is taken; RUN rotates the
// chain, SUM lets the last product land and FIN registers the result. No new request is
// taken until the pass is done. The pass uses one shared multiply-accumulate that the
// cell chain feeds by rotating its coefficient/sample pairs past the head once per cycle.
// Load and clear requests are taken while idle and give no result; a stalled result holds FIN.
// Synchronous reset zeroes all coefficients and the sample history.
module streaming_fir_convolver
  import sfc_pkg::*;
#(
  parameter int TAPS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  // exact sum of TAPS Q2.30 products plus sign headroom
  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    SUM,
    FIN
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           cnt;
  logic                       req_take;
  cell_ctrl_t                 ctrl;
  logic                       mul_en;
  logic                       acc_clr;
  res_t                       mac_result;
  logic signed [SAMPLE_W-1:0] coefs   [TAPS];
  logic signed [SAMPLE_W-1:0] samples [TAPS];
  logic [TAPS-1:0]            load;

  // take a request only between filter passes
  assign req_stall = (state != IDLE);
  assign req_take  = req_valid && !req_stall;

  // shift the new sample in as the request is taken, then rotate until every pair
  // has visited the head once and the chain ends where it started
  assign ctrl.shift  = req_take && (req.op == OP_FILTER);
  assign ctrl.clear  = req_take && (req.op == OP_CLEAR);
  assign ctrl.rotate = (state == RUN);
  assign mul_en      = (state == RUN);
  assign acc_clr     = ctrl.shift;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    // tap indices past the chain hit no cell, so those loads drop
    assign load[k] = req_take && (req.op == OP_LOAD) && (32'(req.tap_index) == k);

    if (k == 0) begin : g_head
      sfc_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .load        (load[k]),
        .load_value  (req.tap_value),
        .prev_sample (req.sample_in),
        .next_coef   (coefs[(k + 1) % TAPS]),
        .next_sample (samples[(k + 1) % TAPS]),
        .coef        (coefs[k]),
        .sample      (samples[k])
      );
    end else begin : g_body
      sfc_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .load        (load[k]),
        .load_value  (req.tap_value),
        .prev_sample (samples[k-1]),
        .next_coef   (coefs[(k + 1) % TAPS]),
        .next_sample (samples[(k + 1) % TAPS]),
        .coef        (coefs[k]),
        .sample      (samples[k])
      );
    end
  end

  // head cell feeds the shared multiplier
  sfc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clr    (acc_clr),
    .mul_en (mul_en),
    .coef   (coefs[0]),
    .sample (samples[0]),
    .result (mac_result)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      // raise valid for a finished sum, drop it once the result is taken
      if (state == FIN && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          cnt <= '0;
          if (ctrl.shift) begin
            state <= RUN;
          end
        end
        RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(TAPS - 1)) begin
            state <= SUM;
          end
        end
        SUM: begin
          // last product lands in the accumulator this cycle
          state <= FIN;
        end
        FIN: begin
          // hold the finished sum until the output register frees up
          if (!res_valid || !res_stall) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == FIN && (!res_valid || !res_stall)) begin
      res <= mac_result;
    end
  end

`ifndef NO_ASSERTIONS
  a_filter_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.op == OP_FILTER) |=> (state == RUN))
    else $error("filter request did not start a pass");

  a_pass_length: assert property (@(posedge clk) disable iff (rst)
    (state == RUN && cnt == CNT_W'(TAPS - 1)) |=> (state == SUM))
    else $error("rotation pass did not end after TAPS cycles");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (state == RUN && $past(state) == RUN) |-> (cnt == CNT_W'($past(cnt) + 1'b1)))
    else $error("rotation counter skipped");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == FIN))
    else $error("result raised outside the finish step");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import sfc_pkg::*;

  localparam int NTAPS       = 64;
  localparam int LATENCY     = NTAPS + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_TAIL  = 40;
  localparam int RAND_ITEMS  = 450;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Coefficient styles for the random segments.
  localparam int STYLE_FULL   = 0;
  localparam int STYLE_SMALL  = 1;
  localparam int STYLE_SPARSE = 2;

  typedef struct {
    req_t req;
    bit   drain;  // hold this request back until every expected result is in
  } pending_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  streaming_fir_convolver #(.TAPS(NTAPS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  // Filter state as the block should hold it: taps and past samples,
  // newest past sample at index 0.
  logic signed [15:0] tap_model     [NTAPS];
  logic signed [15:0] history_model [NTAPS-1];

  pending_t    pending_requests [$];
  res_t        expected_samples [$];
  bit          drain_next;
  int unsigned stim_items;
  int unsigned mismatches, checked, filtered, loaded, cleared, clipped;
  int unsigned cycles;
  int unsigned send_gap, recv_gap;
  int unsigned send_pct, recv_pct;
  bit          quiet;  // tail of the run: no idling on either side

  initial begin
    foreach (tap_model[i]) tap_model[i] = '0;
    foreach (history_model[i]) history_model[i] = '0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycles, what);
    mismatches++;
  endtask

  // Apply one accepted request to the filter state; a filter request yields
  // the rounded, clamped dot product of the taps with the sample window.
  task automatic apply_request(input req_t r);
    logic signed [15:0] x;
    longint             acc;
    longint             rounded;
    res_t               y;
    case (r.op)
      OP_LOAD: begin
        if (r.tap_index < NTAPS) tap_model[r.tap_index] = r.tap_value;
        loaded++;
      end
      OP_CLEAR: begin
        foreach (history_model[i]) history_model[i] = '0;
        cleared++;
      end
      OP_FILTER: begin
        x = r.sample_in;
        acc = longint'(tap_model[0]) * longint'(x);
        for (int k = 1; k < NTAPS; k++)
          acc += longint'(tap_model[k]) * longint'(history_model[k-1]);
        for (int k = NTAPS - 2; k > 0; k--) history_model[k] = history_model[k-1];
        history_model[0] = x;
        // Round half up, then floor-shift back to Q1.15.
        rounded = (acc + 64'sd16384) >>> 15;
        y.saturated = 1'b0;
        if (rounded > 32767) begin
          y.sample_out = 16'sh7fff;
          y.saturated  = 1'b1;
        end else if (rounded < -32768) begin
          y.sample_out = 16'sh8000;
          y.saturated  = 1'b1;
        end else begin
          y.sample_out = rounded[15:0];
        end
        expected_samples.push_back(y);
        filtered++;
      end
      default: ;  // unused selector: nothing changes, no result
    endcase
  endtask

  function automatic int unsigned pick_gap(input int unsigned pct);
    return ($urandom_range(99) < pct) ? $urandom_range(16, 1) : 0;
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [5:0] rnd6();
    return 6'($urandom);
  endfunction

  // Queue one request; unused fields carry whatever the caller passes.
  task automatic enqueue_req(input logic [1:0] op, input logic [15:0] sample,
                             input logic [5:0] idx, input logic [15:0] value);
    pending_t p;
    p.req.op        = op;
    p.req.sample_in = sample;
    p.req.tap_index = idx;
    p.req.tap_value = value;
    p.drain         = drain_next;
    drain_next      = 1'b0;
    pending_requests.push_back(p);
    if (op != OP_UNUSED) stim_items++;
  endtask

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       return 16'h7fff;
        1:       return 16'h8000;
        2:       return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_tap(input int style);
    logic signed [15:0] v;
    v = 16'($urandom);
    case (style)
      STYLE_SMALL:  v = v >>> $urandom_range(9, 4);
      STYLE_SPARSE: if ($urandom_range(7) != 0) v = '0;
      default: ;
    endcase
    return v;
  endfunction

  // Rotate the idling rates now and then so that busy stretches alternate
  // with calm ones; give up at the cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) begin
      send_pct <= pick_rate();
      recv_pct <= pick_rate();
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_samples.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Request driver: hold a stalled request, predict on acceptance, then
  // either idle for a burst or present the next queued request.
  always @(posedge clk) begin
    pending_t nxt;
    logic     drive_valid;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      drive_valid = req_valid;
      if (req_valid && !req_stall) begin
        apply_request(req);
        drive_valid = 1'b0;
      end
      if (!drive_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain && expected_samples.size() > 0)) begin
          nxt = pending_requests.pop_front();
          req <= nxt.req;
          drive_valid = 1'b1;
          if (!quiet) send_gap <= pick_gap(send_pct);
        end
      end
      req_valid <= drive_valid;
      quiet     <= pending_requests.size() < QUIET_TAIL;
    end
  end

  // Result monitor: check each accepted result against the oldest
  // prediction, and stall in random bursts.
  always @(posedge clk) begin
    res_t        want;
    int unsigned gap;
    if (rst) begin
      res_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request waiting",
                                    res.sample_out));
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (want.saturated) clipped++;
          if (res.sample_out !== want.sample_out)
            report_mismatch($sformatf("result %0d: sample_out %0d, want %0d", checked,
                                      res.sample_out, want.sample_out));
          if (res.saturated !== want.saturated)
            report_mismatch($sformatf("result %0d: saturated %b, want %b", checked,
                                      res.saturated, want.saturated));
        end
      end
      if (recv_gap > 0) begin
        res_stall <= 1'b1;
        recv_gap  <= recv_gap - 1;
      end else if (!quiet) begin
        gap = pick_gap(recv_pct);
        res_stall <= (gap > 0);
        if (gap > 0) recv_gap <= gap - 1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    int          style;
    int unsigned nload;
    int unsigned nsamp;
    int unsigned pick;

    // Directed part. Start from reset: zero taps give zero out.
    enqueue_req(OP_FILTER, 16'h7fff, rnd6(), rnd16());
    // Extreme taps at both ends of the line, extreme samples through tap 0.
    enqueue_req(OP_LOAD, rnd16(), 6'd0, 16'h7fff);
    enqueue_req(OP_LOAD, rnd16(), 6'd63, 16'h8000);
    enqueue_req(OP_FILTER, 16'h7fff, rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'h8000, rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'h0000, rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'h0001, rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'hffff, rnd6(), rnd16());
    // Unused selector must leave everything alone.
    enqueue_req(OP_UNUSED, rnd16(), rnd6(), rnd16());
    // Clearing history keeps the taps.
    enqueue_req(OP_CLEAR, rnd16(), rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'h8000, rnd6(), rnd16());
    // Most negative squared: clips high. Loading a tap keeps the history.
    enqueue_req(OP_LOAD, rnd16(), 6'd0, 16'h8000);
    enqueue_req(OP_FILTER, 16'h8000, rnd6(), rnd16());
    // Two most negative taps against full scale: clips low; the first
    // output lands at -32767, just above the bottom of the range, without clipping.
    enqueue_req(OP_LOAD, rnd16(), 6'd1, 16'h8000);
    enqueue_req(OP_CLEAR, rnd16(), rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'h7fff, rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'h7fff, rnd6(), rnd16());
    // Half-way products exercise round half up on both signs.
    enqueue_req(OP_LOAD, rnd16(), 6'd0, 16'h4000);
    enqueue_req(OP_LOAD, rnd16(), 6'd1, 16'h0000);
    enqueue_req(OP_LOAD, rnd16(), 6'd63, 16'h0000);
    enqueue_req(OP_CLEAR, rnd16(), rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'h0001, rnd6(), rnd16());
    enqueue_req(OP_FILTER, 16'hffff, rnd6(), rnd16());

    // Random part: segments of tap loads, an optional clear and a burst of
    // samples, with stray loads, clears and unused selectors mixed in.
    drain_next = 1'b1;
    while (stim_items < RAND_ITEMS) begin
      style = $urandom_range(2);
      if ($urandom_range(3) == 0) drain_next = 1'b1;
      if ($urandom_range(2) == 0) enqueue_req(OP_CLEAR, rnd16(), rnd6(), rnd16());
      nload = ($urandom_range(5) == 0) ? NTAPS : $urandom_range(8, 1);
      for (int i = 0; i < nload; i++)
        enqueue_req(OP_LOAD, rnd16(), (nload == NTAPS) ? 6'(i) : rnd6(),
                    rand_tap(style));
      nsamp = $urandom_range(40, 10);
      for (int i = 0; i < nsamp; i++) begin
        pick = $urandom_range(99);
        if (pick < 4)
          enqueue_req(OP_UNUSED, rnd16(), rnd6(), rnd16());
        else if (pick < 7)
          enqueue_req(OP_LOAD, rnd16(), rnd6(), rand_tap(style));
        else if (pick < 9)
          enqueue_req(OP_CLEAR, rnd16(), rnd6(), rnd16());
        else
          enqueue_req(OP_FILTER, rand_sample(), rnd6(), rnd16());
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, everything back, then let the pipe settle.
    while (pending_requests.size() > 0 || req_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);

    $display("covered %0d filtered samples (%0d clipped), %0d tap loads, %0d clears",
             filtered, clipped, loaded, cleared);
    $display("checked %0d results, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
